// ===== sv/bcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsc_pkg: shared constants, types and helpers
// Block geometry, field widths, register indexes and result word layout for
// the byte/bit chi-squared randomness checker.
// ----------------------------------------------------------------------------
package bcsc_pkg;

  // Block geometry
  localparam int BLOCK_BYTES    = 4096;
  localparam int SUBBLOCK_BYTES = 128;
  localparam int NUM_SUB        = (BLOCK_BYTES + SUBBLOCK_BYTES - 1) / SUBBLOCK_BYTES;
  localparam int SUB_IDX_W      = (NUM_SUB > 1) ? $clog2(NUM_SUB) : 1;
  localparam int SUB_MEM_DEPTH  = 2 ** (SUB_IDX_W + 1);
  localparam int POS_W          = $clog2(BLOCK_BYTES);
  localparam int SBYTE_W        = $clog2(SUBBLOCK_BYTES);
  localparam int BIN_EXPECT     = BLOCK_BYTES / 256;

  // Internal widths
  localparam int CNT_W   = $clog2(BLOCK_BYTES + 1);
  localparam int SUM_W   = 2 * POS_W + 1;
  localparam int ONES_W  = $clog2(SUBBLOCK_BYTES * 8 + 1);
  localparam int ONES_EXPECT = SUBBLOCK_BYTES * 4;

  // Field widths
  localparam int DATA_W       = 8;
  localparam int OFF_W        = 48;
  localparam int BYTE_LIM_W   = 24;
  localparam int BIT_DEV_W    = 10;
  localparam int HINT_W       = 8;
  localparam int SQ_OUT_W     = 24;
  localparam int ONES_OUT_W   = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  localparam int CMP_W  = (ONES_W > BIT_DEV_W) ? ONES_W : BIT_DEV_W;
  localparam int CMPS_W = (SUM_W > BYTE_LIM_W) ? SUM_W : BYTE_LIM_W;

  localparam logic [SUM_W-1:0] SUM_INIT  = SUM_W'(256 * BIN_EXPECT * BIN_EXPECT);
  localparam logic [SUM_W-1:0] TWO_EXP   = SUM_W'(2 * BIN_EXPECT);
  localparam logic [ONES_W-1:0] ONES_EXP = ONES_W'(ONES_EXPECT);

  // Register reset values
  localparam logic [BYTE_LIM_W-1:0] BYTE_LIMIT_RST = 24'd5288;
  localparam logic [BIT_DEV_W-1:0]  BIT_DEV_RST    = 10'd62;
  localparam logic [HINT_W-1:0]     HINT_LIMIT_RST = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_LIMIT = 2'd0,
    CFG_BIT_DEV    = 2'd1,
    CFG_HINT_LIMIT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GS_IDLE,
    GS_SCAN,
    GS_FLUSH
  } gen_state_e;

  typedef struct packed {
    logic                  kind;
    logic                  block_bad;
    logic                  first_bad_in_area;
    logic [OFF_W-1:0]      offset;
    logic [SQ_OUT_W-1:0]   squared_sum;
    logic [ONES_OUT_W-1:0] ones_count;
    logic                  suppressed;
    logic                  last;
  } res_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] b;
    a = (v & 8'h55) + ((v >> 1) & 8'h55);
    b = (a & 8'h33) + ((a >> 2) & 8'h33);
    return 4'((b & 8'h0F) + ((b >> 4) & 8'h0F));
  endfunction

endpackage

// ===== sv/bcsc_if.sv =====
// ----------------------------------------------------------------------------
// bcsc channel interfaces
// Valid/ready channels for input bytes, result words and register writes.
// ----------------------------------------------------------------------------
interface bcsc_in_if;
  import bcsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [OFF_W-1:0]  block_offset;
  logic              first_block_of_area;

  modport source (output valid, data_byte, block_offset, first_block_of_area,
                  input ready);
  modport sink   (input valid, data_byte, block_offset, first_block_of_area,
                  output ready);
endinterface

interface bcsc_out_if;
  import bcsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic                  block_bad;
  logic                  first_bad_in_area;
  logic [OFF_W-1:0]      offset;
  logic [SQ_OUT_W-1:0]   squared_sum;
  logic [ONES_OUT_W-1:0] ones_count;
  logic                  suppressed;
  logic                  last;

  modport source (output valid, kind, block_bad, first_bad_in_area, offset,
                  squared_sum, ones_count, suppressed, last, input ready);
  modport sink   (input valid, kind, block_bad, first_bad_in_area, offset,
                  squared_sum, ones_count, suppressed, last, output ready);
endinterface

interface bcsc_cfg_if;
  import bcsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/block_randomness_chi_square_check_top.sv =====
// ----------------------------------------------------------------------------
// block_randomness_chi_square_check_top
// Streams bytes of fixed-size blocks, keeps a byte histogram and per-subblock
// ones counts, and per block emits a verdict plus suspect subblock offsets.
// ----------------------------------------------------------------------------
//
//  channel  dir  word                                  accepted when
//  -------  ---  ------------------------------------  -----------------------
//  in_ch    in   data_byte, block_offset, first flag   valid && ready
//  out_ch   out  verdict or suspect result             valid && ready
//  cfg_ch   in   register index, write data            valid (ready tied high)
//
//  One byte per cycle. Histogram read-modify-write is pipelined as a memory
//  read, then update/write, forwarding between back-to-back equal bytes.
//  After a block's last byte the verdict is latched, a failing block with hints
//  left has its subblocks scanned, and the final word goes out; out_ch stalls hold them.
//  in_ch stalls only on a block's last byte while the previous block's results
//  are still going out. Reset clears control and histogram valid bits at once.
//
module block_randomness_chi_square_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcsc_in_if.sink     in_ch,
  bcsc_out_if.source  out_ch,
  bcsc_cfg_if.sink    cfg_ch
);
  import bcsc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [BYTE_LIM_W-1:0] byte_limit_q;
  logic [BIT_DEV_W-1:0]  bit_dev_q;
  logic [HINT_W-1:0]     hint_limit_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q <= BYTE_LIMIT_RST;
      bit_dev_q    <= BIT_DEV_RST;
      hint_limit_q <= HINT_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BYTE_LIMIT: byte_limit_q <= BYTE_LIM_W'(cfg_ch.data);
        CFG_BIT_DEV:    bit_dev_q    <= BIT_DEV_W'(cfg_ch.data);
        CFG_HINT_LIMIT: hint_limit_q <= HINT_W'(cfg_ch.data);
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input side: byte position counters, bank (epoch) bit
  // --------------------------------------------------------------------------
  logic                 in_acc;
  logic                 in_rdy;
  logic [POS_W-1:0]     pos_q;
  logic [SBYTE_W-1:0]   sbyte_q;
  logic [SUB_IDX_W-1:0] sidx_q;
  logic                 epoch_q;
  logic                 pos_last;
  logic                 sbyte_last;
  gen_state_e           gs_q, gs_d;

  assign pos_last   = (pos_q == POS_W'(BLOCK_BYTES - 1));
  assign sbyte_last = (sbyte_q == SBYTE_W'(SUBBLOCK_BYTES - 1));
  // Last byte of a block waits until the previous block's results are out.
  assign in_rdy      = !(pos_last && (gs_q != GS_IDLE));
  assign in_ch.ready = in_rdy;
  assign in_acc      = in_ch.valid && in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sbyte_q <= '0;
      sidx_q  <= '0;
      epoch_q <= 1'b0;
    end else if (in_acc) begin
      if (pos_last) begin
        pos_q   <= '0;
        sbyte_q <= '0;
        sidx_q  <= '0;
        epoch_q <= !epoch_q;
      end else begin
        pos_q <= pos_q + POS_W'(1);
        if (sbyte_last) begin
          sbyte_q <= '0;
          sidx_q  <= sidx_q + SUB_IDX_W'(1);
        end else begin
          sbyte_q <= sbyte_q + SBYTE_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: histogram update, squared-sum update, subblock ones
  // --------------------------------------------------------------------------
  logic                 s1_vld_q;
  logic [DATA_W-1:0]    s1_byte_q;
  logic [OFF_W-1:0]     s1_off_q;
  logic                 s1_sfirst_q;
  logic                 s1_slast_q;
  logic                 s1_blast_q;
  logic [SUB_IDX_W-1:0] s1_sidx_q;
  logic                 s1_ep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q   <= in_ch.data_byte;
      s1_off_q    <= in_ch.block_offset;
      s1_sfirst_q <= (sbyte_q == '0);
      s1_slast_q  <= sbyte_last;
      s1_blast_q  <= pos_last;
      s1_sidx_q   <= sidx_q;
      s1_ep_q     <= epoch_q;
    end
  end

  logic                 blk_done;
  assign blk_done = s1_vld_q && s1_blast_q;

  // Histogram memory; valid bits stand in for the per-block clear.
  logic [CNT_W-1:0] hist_mem [256];
  logic [CNT_W-1:0] hist_rd_q;
  logic [255:0]     hvld_q;
  logic             fwd_hit_q;
  logic [CNT_W-1:0] fwd_val_q;
  logic [CNT_W-1:0] k_cur;
  logic [CNT_W-1:0] k_inc;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    if (fwd_hit_q) begin
      k_cur = fwd_val_q;
    end else if (hvld_q[s1_byte_q]) begin
      k_cur = hist_rd_q;
    end else begin
      k_cur = '0;
    end
    k_inc   = k_cur + CNT_W'(1);
    // k -> k+1 adds 2(k-E)+1
    sum_nxt = sum_q + SUM_W'({k_cur, 1'b1}) - TWO_EXP;
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      hist_mem[s1_byte_q] <= k_inc;
    end
    hist_rd_q <= hist_mem[in_ch.data_byte];
    // Write landing at the same edge as the read: forward it.
    fwd_hit_q <= s1_vld_q && !s1_blast_q && (s1_byte_q == in_ch.data_byte);
    fwd_val_q <= k_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvld_q <= '0;
      sum_q  <= SUM_INIT;
    end else if (s1_vld_q) begin
      if (s1_blast_q) begin
        hvld_q <= '0;
        sum_q  <= SUM_INIT;
      end else begin
        hvld_q[s1_byte_q] <= 1'b1;
        sum_q             <= sum_nxt;
      end
    end
  end

  // Subblock ones: running accumulator, finished counts into a two-bank memory
  logic [ONES_W-1:0] acc_q;
  logic [ONES_W-1:0] acc_nxt;
  logic [ONES_W-1:0] sub_mem [SUB_MEM_DEPTH];
  logic [ONES_W-1:0] sub_rd_q;
  logic [SUB_IDX_W-1:0] e_idx_q, e_idx_d;
  logic                 bank_q, bank_d;

  assign acc_nxt = (s1_sfirst_q ? '0 : acc_q) + ONES_W'(popcnt8(s1_byte_q));

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      acc_q <= acc_nxt;
      if (s1_slast_q || s1_blast_q) begin
        sub_mem[{s1_ep_q, s1_sidx_q}] <= acc_nxt;
      end
    end
    sub_rd_q <= sub_mem[{bank_d, e_idx_d}];
  end

  // --------------------------------------------------------------------------
  // Result generator: verdict, then scan of the finished bank
  // --------------------------------------------------------------------------
  res_t              held_q, held_d;
  res_t              push_w;
  res_t              susp_w;
  res_t              out_q;
  logic              out_vld_q;
  logic              out_free;
  logic              push;
  logic [OFF_W-1:0]  base_q, base_d;
  logic [HINT_W-1:0] hints_q, hints_d;
  logic [HINT_W-1:0] hints_eff;
  logic              area_q, area_d, area_eff;
  logic              pclr_q, pclr_d;
  logic              rv_q;
  logic              bad;
  logic [ONES_W-1:0] dev;
  logic              suspect;
  logic              hint_hits;

  assign out_free  = !out_vld_q || out_ch.ready;
  assign bad       = CMPS_W'(sum_nxt) > CMPS_W'(byte_limit_q);
  assign dev       = (sub_rd_q >= ONES_EXP) ? (sub_rd_q - ONES_EXP) : (ONES_EXP - sub_rd_q);
  assign suspect   = CMP_W'(dev) > CMP_W'(bit_dev_q);
  assign hint_hits = ((9'(hints_q) + 9'd1) == 9'(hint_limit_q));

  always_comb begin
    susp_w                   = held_q;
    susp_w.kind              = 1'b1;
    susp_w.block_bad         = 1'b1;
    susp_w.offset            = base_q + OFF_W'(e_idx_q * SUBBLOCK_BYTES);
    susp_w.ones_count        = ONES_OUT_W'(sub_rd_q);
    susp_w.suppressed        = hint_hits;
    susp_w.last              = 1'b0;
  end

  always_comb begin
    gs_d      = gs_q;
    held_d    = held_q;
    e_idx_d   = e_idx_q;
    hints_d   = hints_q;
    area_d    = area_q;
    pclr_d    = pclr_q;
    bank_d    = bank_q;
    base_d    = base_q;
    push      = 1'b0;
    push_w    = held_q;
    area_eff  = area_q;
    hints_eff = hints_q;
    case (gs_q)
      GS_IDLE: begin
        // Area restart requested by an earlier first byte takes effect here,
        // after the previous block's hints are counted.
        if (pclr_q) begin
          area_eff = 1'b0;
          hints_eff = '0;
          pclr_d    = 1'b0;
        end
        area_d  = area_eff;
        hints_d = hints_eff;
        if (blk_done) begin
          held_d.kind              = 1'b0;
          held_d.block_bad         = bad;
          held_d.first_bad_in_area = bad && !area_eff;
          held_d.offset            = s1_off_q;
          held_d.squared_sum       = SQ_OUT_W'(sum_nxt);
          held_d.ones_count        = '0;
          held_d.suppressed        = 1'b0;
          held_d.last              = 1'b0;
          area_d  = area_eff || bad;
          base_d  = s1_off_q;
          bank_d  = s1_ep_q;
          e_idx_d = '0;
          gs_d    = (bad && (hints_eff < hint_limit_q)) ? GS_SCAN : GS_FLUSH;
        end
      end
      GS_SCAN: begin
        if (rv_q) begin
          if (suspect) begin
            if (out_free) begin
              push    = 1'b1;
              held_d  = susp_w;
              hints_d = hints_q + HINT_W'(1);
              if (hint_hits || (e_idx_q == SUB_IDX_W'(NUM_SUB - 1))) begin
                gs_d = GS_FLUSH;
              end else begin
                e_idx_d = e_idx_q + SUB_IDX_W'(1);
              end
            end
          end else if (e_idx_q == SUB_IDX_W'(NUM_SUB - 1)) begin
            gs_d = GS_FLUSH;
          end else begin
            e_idx_d = e_idx_q + SUB_IDX_W'(1);
          end
        end
      end
      GS_FLUSH: begin
        if (out_free) begin
          push        = 1'b1;
          push_w.last = 1'b1;
          gs_d        = GS_IDLE;
        end
      end
      default: begin
        gs_d = GS_IDLE;
      end
    endcase
    if (in_acc && (pos_q == '0) && in_ch.first_block_of_area) begin
      pclr_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q      <= GS_IDLE;
      e_idx_q   <= '0;
      hints_q   <= '0;
      area_q    <= 1'b0;
      pclr_q    <= 1'b0;
      bank_q    <= 1'b0;
      rv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      gs_q    <= gs_d;
      e_idx_q <= e_idx_d;
      hints_q <= hints_d;
      area_q  <= area_d;
      pclr_q  <= pclr_d;
      bank_q  <= bank_d;
      // Read data lines up with e_idx_q once rv_q, a registered copy of the scan state, is set;
      // the first scan cycle waits so the bank's final write has landed.
      rv_q    <= (gs_q == GS_SCAN);
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    base_q <= base_d;
    if (push) begin
      out_q <= push_w;
    end
  end

  assign out_ch.valid             = out_vld_q;
  assign out_ch.kind              = out_q.kind;
  assign out_ch.block_bad         = out_q.block_bad;
  assign out_ch.first_bad_in_area = out_q.first_bad_in_area;
  assign out_ch.offset            = out_q.offset;
  assign out_ch.squared_sum       = out_q.squared_sum;
  assign out_ch.ones_count        = out_q.ones_count;
  assign out_ch.suppressed        = out_q.suppressed;
  assign out_ch.last              = out_q.last;

`ifndef SYNTHESIS
  a_last_byte_gen_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_last) |-> (gs_q == GS_IDLE))
    else $error("block end accepted while results pending");

  a_done_starts_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_done |=> (gs_q != GS_IDLE))
    else $error("block end did not start result generation");

  a_scan_only_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gs_q == GS_SCAN) |-> held_q.block_bad)
    else $error("subblock scan on a passing block");

  a_scan_data_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((gs_q == GS_SCAN) && $past(gs_q == GS_SCAN)) |-> rv_q)
    else $error("scan read data not aligned");
`endif

endmodule

// ===== tb/sv/tb_block_randomness_chi_square_check_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_randomness_chi_square_check_top
// Self-checking bench for the byte/bit chi-squared checker. Streams whole
// 4096-byte blocks, predicts the verdict and suspect subblock words with its
// own histogram and ones-count model, and compares every output word field by
// field. Directed blocks hit the limits and area/hint rules, a long output
// hold-off backs up the input, and random blocks under random limits follow
// with idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_block_randomness_chi_square_check_top;
  import bcsc_pkg::*;

  // Index 3 of the register port maps to no register; writes must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Slack after the last expected word: covers the generator scan of the
  // remaining subblocks plus the histogram pipeline, rounded up.
  localparam int DRAIN_CYCLES = 64;

  // Block content recipes.
  typedef enum int {
    FILL_UNIFORM,   // independent random bytes, sum near 4080
    FILL_PERMUTE,   // every value exactly 16 times, sum zero
    FILL_NARROW,    // values from a small window, always fails
    FILL_BITBIAS,   // AND/OR of two random bytes, every subblock skewed
    FILL_MARKED,    // balanced popcount-4 bytes with some skewed subblocks
    FILL_NEAR       // permutation with some bytes copied over, sum near limit
  } fill_kind_e;

  logic clk_i;
  logic rst_ni;

  bcsc_in_if  in_ch ();
  bcsc_out_if out_ch ();
  bcsc_cfg_if cfg_ch ();

  block_randomness_chi_square_check_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  logic [7:0] blk [BLOCK_BYTES];   // contents of the block being sent
  int         src_idle_pct;        // chance per word that the sender idles
  int         snk_idle_pct;        // chance per cycle that ready drops
  int         hold_cycles;         // long hold-off, counted down by the sink
  int         err_cnt;

  // Checker model: limits, histogram, per-subblock ones, area tracking.
  logic [BYTE_LIM_W-1:0] lim_sum;
  logic [BIT_DEV_W-1:0]  lim_dev;
  logic [HINT_W-1:0]     lim_hint;
  int                    hist_cnt [256];
  longint                sq_sum;
  int                    byte_pos;
  int                    sub_ones [NUM_SUB];
  logic                  area_flagged;
  int                    hints_used;
  res_t                  pending [$];   // verdict/suspect words still owed

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Safety net: roughly ten times the slowest legal run.
  initial begin
    #(60_000_000);
    $display("block_randomness_chi_square_check_top verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  task automatic clear_block_model();
    foreach (hist_cnt[i]) hist_cnt[i] = 0;
    foreach (sub_ones[i]) sub_ones[i] = 0;
    sq_sum   = 256 * BIN_EXPECT * BIN_EXPECT;
    byte_pos = 0;
  endtask

  // Runs once per accepted input word. On a block's last byte it queues the
  // verdict and then the suspect words; the word before each newly found
  // suspect loses its last flag.
  task automatic chi_square_predict(input logic [7:0] d, input logic [OFF_W-1:0] ofs,
                                    input logic area_start);
    res_t held;
    int   dev;
    logic bad;
    // area start only counts on a block's first byte
    if (byte_pos == 0 && area_start) begin
      area_flagged = 1'b0;
      hints_used   = 0;
    end
    // bin k -> k+1 adds 2(k-E)+1
    sq_sum = sq_sum + 2 * hist_cnt[d] + 1 - 2 * BIN_EXPECT;
    hist_cnt[d]++;
    sub_ones[byte_pos / SUBBLOCK_BYTES] += $countones(d);
    if (byte_pos != BLOCK_BYTES - 1) begin
      byte_pos++;
    end else begin
      bad  = (sq_sum > longint'(lim_sum));
      held = '0;
      held.block_bad         = bad;
      held.first_bad_in_area = bad && !area_flagged;
      held.offset            = ofs;
      held.squared_sum       = SQ_OUT_W'(sq_sum);
      held.last              = 1'b1;
      if (bad) area_flagged = 1'b1;
      for (int s = 0; bad && s < NUM_SUB && hints_used < int'(lim_hint); s++) begin
        dev = sub_ones[s] - ONES_EXPECT;
        if (dev < 0) dev = -dev;
        if (dev > int'(lim_dev)) begin
          held.last = 1'b0;
          pending.push_back(held);
          hints_used++;
          held.kind       = 1'b1;
          held.offset     = ofs + OFF_W'(s * SUBBLOCK_BYTES);   // wraps at 48 bits
          held.ones_count = ONES_OUT_W'(sub_ones[s]);
          held.suppressed = (hints_used == int'(lim_hint));
          held.last       = 1'b1;
        end
      end
      pending.push_back(held);
      clear_block_model();
    end
  endtask

  task automatic check_field(input string name, input logic [OFF_W-1:0] exp_v,
                             input logic [OFF_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Monitor: register writes and input words feed the model, output words are
  // checked against the oldest expectation. All sampled at the rising edge.
  always @(posedge clk_i) begin : monitor
    res_t exp_w;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BYTE_LIMIT: lim_sum  = cfg_ch.data[BYTE_LIM_W-1:0];
          CFG_BIT_DEV:    lim_dev  = cfg_ch.data[BIT_DEV_W-1:0];
          CFG_HINT_LIMIT: lim_hint = cfg_ch.data[HINT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        chi_square_predict(in_ch.data_byte, in_ch.block_offset, in_ch.first_block_of_area);
      if (out_ch.valid && out_ch.ready) begin
        if (pending.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0b offset %0h",
                   $time, out_ch.kind, out_ch.offset);
          err_cnt++;
        end else begin
          exp_w = pending.pop_front();
          check_field("kind",              exp_w.kind,              out_ch.kind);
          check_field("block_bad",         exp_w.block_bad,         out_ch.block_bad);
          check_field("first_bad_in_area", exp_w.first_bad_in_area, out_ch.first_bad_in_area);
          check_field("offset",            exp_w.offset,            out_ch.offset);
          check_field("squared_sum",       exp_w.squared_sum,       out_ch.squared_sum);
          check_field("ones_count",        exp_w.ones_count,        out_ch.ones_count);
          check_field("suppressed",        exp_w.suppressed,        out_ch.suppressed);
          check_field("last",              exp_w.last,              out_ch.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random ready, or held low while a hold-off is counting down
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [OFF_W-1:0] rand_offset();
    return OFF_W'({$urandom, $urandom});
  endfunction

  function automatic logic [7:0] byte_with_ones(input int n);
    logic [7:0] v;
    v = 8'($urandom);
    while ($countones(v) != n) v = 8'($urandom);
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back words need no re-raise.
  task automatic send_byte(input logic [7:0] d, input logic [OFF_W-1:0] ofs,
                           input logic area_start);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid               <= 1'b1;
    in_ch.data_byte           <= d;
    in_ch.block_offset        <= ofs;
    in_ch.first_block_of_area <= area_start;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Offset only counts on the last byte and the area flag only on the first;
  // everywhere else both carry noise that must be ignored.
  task automatic send_block(input logic [OFF_W-1:0] ofs, input logic area_start);
    logic [OFF_W-1:0] o;
    logic             f;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      o = (i == BLOCK_BYTES - 1) ? ofs : rand_offset();
      f = (i == 0) ? area_start : 1'($urandom_range(0, 1));
      send_byte(blk[i], o, f);
    end
  endtask

  // Registers only change with the block quiet: input dropped, every owed word
  // received and the generator's trailing scan given time to finish.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic fill_const(input logic [7:0] v);
    foreach (blk[i]) blk[i] = v;
  endtask

  task automatic fill_permutation();
    int         j;
    logic [7:0] t;
    foreach (blk[i]) blk[i] = 8'(i);
    for (int i = BLOCK_BYTES - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      t      = blk[i];
      blk[i] = blk[j];
      blk[j] = t;
    end
  endtask

  // Every subblock holds exactly 512 ones except n_marked chosen ones, which
  // are pushed far off (all zeros, all ones, or dense bytes). The block always
  // fails the byte test, so the suspect count is exactly n_marked, hint allowing.
  task automatic fill_marked(input int n_marked);
    int order [NUM_SUB];
    int j, t, s;
    foreach (order[i]) order[i] = i;
    for (int i = NUM_SUB - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (blk[i]) blk[i] = byte_with_ones(4);
    for (int m = 0; m < n_marked; m++) begin
      s = order[m];
      case ($urandom_range(0, 2))
        0:       for (int i = 0; i < SUBBLOCK_BYTES; i++) blk[s*SUBBLOCK_BYTES+i] = 8'h00;
        1:       for (int i = 0; i < SUBBLOCK_BYTES; i++) blk[s*SUBBLOCK_BYTES+i] = 8'hFF;
        default: for (int i = 0; i < SUBBLOCK_BYTES; i++)
                   blk[s*SUBBLOCK_BYTES+i] = byte_with_ones($urandom_range(6, 7));
      endcase
    end
  endtask

  // Ones counts right on the default bit limit: 574 and 450 sit exactly 62
  // off (pass), 575 and 449 sit 63 off (suspect). Rest exactly 512.
  task automatic fill_deviation_edge();
    foreach (blk[i]) blk[i] = byte_with_ones(4);
    for (int i = 0; i < 62; i++) blk[i]                  = byte_with_ones(5);
    for (int i = 0; i < 63; i++) blk[SUBBLOCK_BYTES+i]   = byte_with_ones(5);
    for (int i = 0; i < 62; i++) blk[2*SUBBLOCK_BYTES+i] = byte_with_ones(3);
    for (int i = 0; i < 63; i++) blk[3*SUBBLOCK_BYTES+i] = byte_with_ones(3);
  endtask

  task automatic fill_block(input fill_kind_e kind);
    int lo, span, copies;
    case (kind)
      FILL_UNIFORM: foreach (blk[i]) blk[i] = 8'($urandom);
      FILL_PERMUTE: fill_permutation();
      FILL_NARROW: begin
        lo   = $urandom_range(0, 255);
        span = $urandom_range(0, 63);
        foreach (blk[i]) blk[i] = 8'(lo + $urandom_range(0, span));
      end
      FILL_BITBIAS: begin
        if ($urandom_range(0, 1))
          foreach (blk[i]) blk[i] = 8'($urandom) & 8'($urandom);
        else
          foreach (blk[i]) blk[i] = 8'($urandom) | 8'($urandom);
      end
      FILL_MARKED: fill_marked($urandom_range(1, NUM_SUB));
      default: begin
        // each copied byte moves the sum by about 2
        fill_permutation();
        copies = $urandom_range(0, 3000);
        repeat (copies)
          blk[$urandom_range(0, BLOCK_BYTES-1)] = blk[$urandom_range(0, BLOCK_BYTES-1)];
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset limits: zero sum, maximum sum with wrapping suspect offsets,
  // exhausted hints in the same area, and the bit limit's exact boundary.
  task automatic test_defaults();
    fill_permutation();
    send_block('0, 1'b1);
    fill_const(8'hFF);
    send_block('1, 1'b0);
    fill_const(8'h00);
    send_block(rand_offset(), 1'b0);
    fill_deviation_edge();
    send_block(rand_offset(), 1'b1);
  endtask

  // Hint budget across an area, including lowering and raising it mid-area,
  // hint zero, and a full 32-suspect block that wraps past the top offset.
  task automatic test_area_hints();
    write_reg(CFG_HINT_LIMIT, 24'd10);
    fill_marked(4);
    send_block(rand_offset(), 1'b1);
    write_reg(CFG_HINT_LIMIT, 24'd2);     // already spent 4: nothing more
    fill_marked(4);
    send_block(rand_offset(), 1'b0);
    write_reg(CFG_HINT_LIMIT, 24'd5);     // one left, and it is the suppressed one
    fill_marked(4);
    send_block(rand_offset(), 1'b0);
    write_reg(CFG_HINT_LIMIT, 24'd0);
    fill_marked(8);
    send_block(rand_offset(), 1'b1);
    write_reg(CFG_HINT_LIMIT, 24'hFFFFFF); // upper bits dropped: 255
    fill_marked(NUM_SUB);
    send_block(48'hFFFF_FFFF_F800, 1'b1);
  endtask

  // Extreme byte and bit limits, register masking and the unused index.
  task automatic test_limit_extremes();
    write_reg(CFG_BYTE_LIMIT, 24'd0);
    fill_permutation();                   // zero is not above zero
    send_block(rand_offset(), 1'b1);
    fill_block(FILL_UNIFORM);
    send_block(rand_offset(), 1'b0);
    write_reg(CFG_BYTE_LIMIT, 24'hFFFFFF);
    fill_const(8'hA5);                    // even the maximum sum passes
    send_block(rand_offset(), 1'b1);
    write_reg(CFG_SPARE, 24'd0);          // must leave the byte limit alone
    fill_const(8'h3C);
    send_block(rand_offset(), 1'b0);
    write_reg(CFG_BYTE_LIMIT, 24'(BYTE_LIMIT_RST));
    write_reg(CFG_BIT_DEV, 24'hFFFE00);   // low bits give 512: no suspect possible
    fill_marked(NUM_SUB);
    send_block(rand_offset(), 1'b1);
    write_reg(CFG_BIT_DEV, 24'hFFFC00);   // low bits give 0
    fill_deviation_edge();
    send_block(rand_offset(), 1'b1);
    write_reg(CFG_BIT_DEV, 24'(BIT_DEV_RST));
  endtask

  // Output held low for longer than two blocks take to stream: the generator
  // backs up and the input must stall on the next block's last byte.
  task automatic test_backpressure();
    int saved_idle;
    write_reg(CFG_HINT_LIMIT, 24'd255);
    saved_idle   = src_idle_pct;
    src_idle_pct = 0;
    hold_cycles  = 3 * BLOCK_BYTES;
    fill_marked(NUM_SUB);
    send_block(rand_offset(), 1'b1);
    fill_marked(NUM_SUB);
    send_block(rand_offset(), 1'b0);
    fill_block(FILL_PERMUTE);
    send_block(rand_offset(), 1'b0);
    src_idle_pct = saved_idle;
    wait_idle();
  endtask

  // Random blocks under random limits, in three idle profiles.
  task automatic test_random_blocks();
    logic [CFG_DATA_W-1:0] d;
    logic [OFF_W-1:0]      ofs;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 15; snk_idle_pct = 57; end
        1:       begin src_idle_pct = 57; snk_idle_pct = 15; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      d = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(3500, 6500));
      write_reg(CFG_BYTE_LIMIT, d);
      d = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(0, 120));
      write_reg(CFG_BIT_DEV, d);
      d = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(0, 12));
      write_reg(CFG_HINT_LIMIT, d);
      for (int b = 0; b < 10; b++) begin
        fill_block(fill_kind_e'($urandom_range(0, 5)));
        ofs = ($urandom_range(0, 3) == 0) ? ~OFF_W'($urandom_range(0, 4095)) : rand_offset();
        send_block(ofs, ($urandom_range(0, 2) == 0));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    err_cnt                   = 0;
    hold_cycles               = 0;
    src_idle_pct              = 15;
    snk_idle_pct              = 57;
    in_ch.valid               = 1'b0;
    in_ch.data_byte           = '0;
    in_ch.block_offset        = '0;
    in_ch.first_block_of_area = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = CFG_BYTE_LIMIT;
    cfg_ch.data               = '0;
    lim_sum                   = BYTE_LIMIT_RST;
    lim_dev                   = BIT_DEV_RST;
    lim_hint                  = HINT_LIMIT_RST;
    area_flagged              = 1'b0;
    hints_used                = 0;
    clear_block_model();
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_defaults();
    test_area_hints();
    test_limit_extremes();
    test_backpressure();
    test_random_blocks();

    wait_idle();
    if (err_cnt == 0) begin
      $display("block_randomness_chi_square_check_top verification clean");
    end else begin
      $display("block_randomness_chi_square_check_top verification failed");
    end
    $finish;
  end

endmodule
